// ===== hw/rtl/crl_pkg.sv =====
package crl_pkg;

    // Packets granted per poll at most, and rate table entries.
    localparam int BURST        = 32;
    localparam int RATE_ENTRIES = 64;
    localparam int TABLE_MAX    = 64;
    localparam int TABLE_LEN    = (RATE_ENTRIES < TABLE_MAX) ? RATE_ENTRIES : TABLE_MAX;
    localparam int TABLE_AW     = (TABLE_LEN > 1) ? $clog2(TABLE_LEN) : 1;

    localparam logic [39:0] CAP_MAX = 40'hFF_FFFF_FFFF;

    // Configuration port.
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 33;

    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HZ     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SENDER_COUNT = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_RATE   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACE_ENABLE = 4'd3;

    localparam logic [32:0] CLOCK_HZ_RST     = 33'd1000000000;
    localparam logic [6:0]  SENDER_COUNT_RST = 7'd1;
    localparam logic [31:0] FIXED_RATE_RST   = 32'd1000000;

    typedef enum logic [1:0] {
        MODE_START  = 2'd0,
        MODE_POLL   = 2'd1,
        MODE_REPORT = 2'd2,
        MODE_TWRITE = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode       mode;
        logic [63:0] timestamp;
        logic [5:0]  sent_count;
        logic [5:0]  table_index;
        logic [31:0] table_rate;
    } t_in_item;

    typedef struct packed {
        logic [5:0]  grant_count;
        logic [5:0]  rate_step;
        logic [63:0] credit_balance;
    } t_out_item;

    typedef enum logic [4:0] {
        S_IDLE,
        S_START,
        S_POLL,
        S_POLL_ADD,
        S_POLL_CHK,
        S_MULT,
        S_SUB,
        S_CAP,
        S_STEP,
        S_TWRITE,
        S_FETCH,
        S_LOAD_PER,
        S_LOAD_Q,
        S_DIV,
        S_SET_RATE,
        S_GRANT,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        DIV_PER,
        DIV_Q,
        DIV_GRANT
    } t_div_op;

endpackage

// ===== hw/rtl/credit_packet_rate_limiter.sv =====
// Channel   Direction  Handshake                    Payload
// input     in         i_in_valid  / o_in_ready     i_in_data  (t_in_item)
// result    out        o_out_valid / i_out_ready    o_out_data (t_out_item)
// config    in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// One request at a time; every request yields one result. A radix-2 shift and
// subtract divider, one quotient bit per cycle, does the long steps: a start runs
// two divisions, a poll one division or none when no packet is due, a report
// none, or two when trace mode recomputes the rate, and a table write none.
// Reset (i_rst_n low, synchronous) restores the register defaults and clears
// the credit state; the rate table is not cleared. A result held back by
// i_out_ready stays in the output register while the next request is accepted.
module credit_packet_rate_limiter
    import crl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers.
    logic [32:0] r_clock_hz;
    logic [6:0]  r_sender_count;
    logic [31:0] r_fixed_rate;
    logic        r_trace;

    // Limiter state.
    t_state      r_state, n_state;
    t_in_item    r_item;
    logic [63:0] r_credits, n_credits;
    logic [63:0] r_last_time, n_last_time;
    logic [33:0] r_packet_cost, n_packet_cost;
    logic [39:0] r_credit_cap, n_credit_cap;
    logic [5:0]  r_step_index, n_step_index;
    logic [63:0] r_step_time, n_step_time;
    logic [63:0] r_tmp, n_tmp;
    logic        r_set_cap, n_set_cap;
    logic [5:0]  r_grant, n_grant;

    // Shared divider.
    t_div_op     r_div_op, n_div_op;
    logic [63:0] r_num, n_num;
    logic [34:0] r_rem, n_rem;
    logic [33:0] r_den, n_den;
    logic [6:0]  r_cnt, n_cnt;

    // Output register.
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out_data, n_out_data;

    // Table memory.
    logic                ram_we;
    logic                ram_re;
    logic [31:0]         ram_rdata;

    logic        in_acc;
    logic        out_free;
    logic [34:0] div_trial;
    logic        div_bit;
    logic [6:0]  sender_eff;
    logic [31:0] rate_sel;
    logic [31:0] per_rate;
    logic [33:0] quot;
    logic [63:0] cap_prod;
    logic [39:0] debit;
    logic [64:0] credit_sum;
    logic [63:0] step_gap;
    logic        tidx_ok;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // One restoring divider step: shift in the next numerator bit, try the
    // subtract, and shift the quotient bit into the freed low end.
    assign div_trial = {r_rem[33:0], r_num[63]};
    assign div_bit   = (div_trial >= {1'b0, r_den});

    assign sender_eff = (r_sender_count == 7'd0) ? 7'd1 : r_sender_count;
    assign rate_sel   = r_trace ? ram_rdata : r_fixed_rate;
    assign per_rate   = (r_num[31:0] == 32'd0) ? 32'd1 : r_num[31:0];
    assign quot       = r_num[33:0];
    assign cap_prod   = {30'd0, quot} * 64'(BURST);
    assign debit      = {34'd0, r_item.sent_count} * {6'd0, r_packet_cost};
    assign credit_sum = {1'b0, r_credits} + {1'b0, r_tmp};
    assign step_gap   = r_item.timestamp - r_step_time;
    assign tidx_ok    = ({1'b0, r_item.table_index} < 7'(TABLE_LEN));

    assign ram_we = (r_state == S_TWRITE) && tidx_ok;
    assign ram_re = (r_state == S_FETCH);

    crl_ram #(
        .WIDTH (32),
        .DEPTH (TABLE_LEN)
    ) u_rate_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_item.table_index[TABLE_AW-1:0]),
        .i_wdata (r_item.table_rate),
        .i_re    (ram_re),
        .i_raddr (r_step_index[TABLE_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Configuration writes land only while the block is idle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_hz     <= CLOCK_HZ_RST;
            r_sender_count <= SENDER_COUNT_RST;
            r_fixed_rate   <= FIXED_RATE_RST;
            r_trace        <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_CLOCK_HZ:     r_clock_hz     <= i_cfg_data[32:0];
                CFG_SENDER_COUNT: r_sender_count <= i_cfg_data[6:0];
                CFG_FIXED_RATE:   r_fixed_rate   <= i_cfg_data[31:0];
                CFG_TRACE_ENABLE: r_trace        <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_in_data.mode)
                        MODE_START:  n_state = S_START;
                        MODE_POLL:   n_state = S_POLL;
                        MODE_REPORT: n_state = S_MULT;
                        MODE_TWRITE: n_state = S_TWRITE;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_START:    n_state = S_FETCH;
            S_FETCH:    n_state = S_LOAD_PER;
            S_LOAD_PER: n_state = S_DIV;
            S_LOAD_Q:   n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == 7'd1) begin
                    unique case (r_div_op)
                        DIV_PER:   n_state = S_LOAD_Q;
                        DIV_Q:     n_state = S_SET_RATE;
                        DIV_GRANT: n_state = S_GRANT;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_SET_RATE: n_state = S_DONE;
            S_POLL:     n_state = S_POLL_ADD;
            S_POLL_ADD: n_state = S_POLL_CHK;
            S_POLL_CHK: begin
                if (r_packet_cost != 34'd0 && r_credits >= {30'd0, r_packet_cost}) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_GRANT:    n_state = S_DONE;
            S_MULT:     n_state = S_SUB;
            S_SUB:      n_state = S_CAP;
            S_CAP:      n_state = r_trace ? S_STEP : S_DONE;
            S_STEP:     n_state = S_FETCH;
            S_TWRITE:   n_state = S_DONE;
            S_DONE:     n_state = out_free ? S_IDLE : S_DONE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        n_credits     = r_credits;
        n_last_time   = r_last_time;
        n_packet_cost = r_packet_cost;
        n_credit_cap  = r_credit_cap;
        n_step_index  = r_step_index;
        n_step_time   = r_step_time;
        n_tmp         = r_tmp;
        n_set_cap     = r_set_cap;
        n_grant       = r_grant;
        n_div_op      = r_div_op;
        n_num         = r_num;
        n_rem         = r_rem;
        n_den         = r_den;
        n_cnt         = r_cnt;
        n_out_valid   = r_out_valid;
        n_out_data    = r_out_data;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                n_grant   = 6'd0;
                n_set_cap = 1'b0;
            end
            S_START: begin
                n_credits    = 64'd0;
                n_step_index = 6'd0;
                n_last_time  = r_item.timestamp;
                n_step_time  = r_item.timestamp;
                n_set_cap    = 1'b1;
            end
            S_LOAD_PER: begin
                // per-sender rate = rate / senders
                n_num    = {rate_sel, 32'd0};
                n_rem    = 35'd0;
                n_den    = {27'd0, sender_eff};
                n_cnt    = 7'd32;
                n_div_op = DIV_PER;
            end
            S_LOAD_Q: begin
                // cost quotient = clock_hz / per-sender rate
                n_num    = {r_clock_hz, 31'd0};
                n_rem    = 35'd0;
                n_den    = {2'd0, per_rate};
                n_cnt    = 7'd33;
                n_div_op = DIV_Q;
            end
            S_DIV: begin
                n_rem = div_bit ? (div_trial - {1'b0, r_den}) : div_trial;
                n_num = {r_num[62:0], div_bit};
                n_cnt = r_cnt - 7'd1;
            end
            S_SET_RATE: begin
                n_packet_cost = (quot == 34'd0) ? 34'd1 : quot;
                if (r_set_cap) begin
                    n_credit_cap = (cap_prod > {24'd0, CAP_MAX}) ? CAP_MAX : cap_prod[39:0];
                end
            end
            S_POLL: begin
                n_tmp       = r_item.timestamp - r_last_time;
                n_last_time = r_item.timestamp;
            end
            S_POLL_ADD: begin
                n_credits = credit_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : credit_sum[63:0];
            end
            S_POLL_CHK: begin
                n_num    = r_credits;
                n_rem    = 35'd0;
                n_den    = r_packet_cost;
                n_cnt    = 7'd64;
                n_div_op = DIV_GRANT;
            end
            S_GRANT: begin
                n_grant = (r_num > 64'(BURST)) ? 6'(BURST) : r_num[5:0];
            end
            S_MULT: begin
                n_tmp = {24'd0, debit};
            end
            S_SUB: begin
                n_credits = (r_credits > r_tmp) ? (r_credits - r_tmp) : 64'd0;
            end
            S_CAP: begin
                if (r_credits > {24'd0, r_credit_cap}) begin
                    n_credits = {24'd0, r_credit_cap};
                end
            end
            S_STEP: begin
                // Advance the trace position once more than a second has gone by.
                if (step_gap > {31'd0, r_clock_hz}) begin
                    n_step_time = r_item.timestamp;
                    n_set_cap   = 1'b1;
                    if ((7'(r_step_index) + 7'd1) < 7'(TABLE_LEN)) begin
                        n_step_index = r_step_index + 6'd1;
                    end else begin
                        n_step_index = 6'd0;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid                = 1'b1;
                    n_out_data.grant_count    = r_grant;
                    n_out_data.rate_step      = r_step_index;
                    n_out_data.credit_balance = r_credits;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_credits     <= 64'd0;
            r_last_time   <= 64'd0;
            r_packet_cost <= 34'd0;
            r_credit_cap  <= 40'd0;
            r_step_index  <= 6'd0;
            r_step_time   <= 64'd0;
            r_set_cap     <= 1'b0;
            r_grant       <= 6'd0;
            r_div_op      <= DIV_PER;
            r_cnt         <= 7'd0;
        end else begin
            r_state       <= n_state;
            r_out_valid   <= n_out_valid;
            r_credits     <= n_credits;
            r_last_time   <= n_last_time;
            r_packet_cost <= n_packet_cost;
            r_credit_cap  <= n_credit_cap;
            r_step_index  <= n_step_index;
            r_step_time   <= n_step_time;
            r_set_cap     <= n_set_cap;
            r_grant       <= n_grant;
            r_div_op      <= n_div_op;
            r_cnt         <= n_cnt;
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= i_in_data;
        end
        r_tmp      <= n_tmp;
        r_num      <= n_num;
        r_rem      <= n_rem;
        r_den      <= n_den;
        r_out_data <= n_out_data;
    end

`ifndef SYNTH
    // The divider never runs with an exhausted step count.
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt != 7'd0))
        else $error("divider running with zero step count");

    // A recomputed rate always leaves a usable cost.
    a_cost_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SET_RATE) |=> (r_packet_cost != 34'd0))
        else $error("packet cost zero after rate update");

    // A report leaves the credits within the cap.
    a_cap_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CAP) |=> (r_credits <= {24'd0, r_credit_cap}))
        else $error("credits above cap after report");
`endif

endmodule

// ===== hw/rtl/crl_ram.sv =====
module crl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

// Random and directed check of the credit rate limiter: requests go in on the
// input channel, a predictor beside the block works out the grant, table step
// and credit balance of each one, and every result coming out is compared with
// the oldest prediction still owed.
module testbench;
    import crl_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_AT     = 250;   // result count that starts the long hold-off
    localparam int HOLD_CYCLES = 600;
    localparam int MAX_REPORTS = 10;

    // Unused register slot; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'd15;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_plan;

    // Predicts the limiter result for every accepted request and holds the
    // predictions until the block hands back its results.
    class grant_ledger;
        logic [32:0] clock_hz;
        logic [6:0]  senders;
        logic [31:0] fixed_rate;
        logic        trace_on;
        logic [63:0] credits;
        logic [63:0] last_ts;
        logic [63:0] step_ts;
        logic [33:0] cost;
        logic [39:0] cap;
        logic [5:0]  rate_pos;
        logic [31:0] rate_table [TABLE_MAX];
        t_out_item   owed_results [$];
        int          mismatches;

        function new();
            clock_hz   = CLOCK_HZ_RST;
            senders    = SENDER_COUNT_RST;
            fixed_rate = FIXED_RATE_RST;
            trace_on   = 1'b0;
            credits    = '0;
            last_ts    = '0;
            step_ts    = '0;
            cost       = '0;
            cap        = '0;
            rate_pos   = '0;
            mismatches = 0;
            foreach (rate_table[i]) rate_table[i] = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                CFG_CLOCK_HZ:     clock_hz   = data[32:0];
                CFG_SENDER_COUNT: senders    = data[6:0];
                CFG_FIXED_RATE:   fixed_rate = data[31:0];
                CFG_TRACE_ENABLE: trace_on   = data[0];
                default: ;
            endcase
        endfunction

        // Clock cycles per packet for one sender; a zero share counts as one.
        function logic [32:0] cycles_per_packet(logic [31:0] rate);
            logic [31:0] share;
            share = rate / ((senders == '0) ? 7'd1 : senders);
            if (share == '0) share = 32'd1;
            return clock_hz / share;
        endfunction

        function void set_cap(logic [32:0] q);
            logic [63:0] full;
            full = {31'b0, q} * BURST;
            cap  = (full > {24'b0, CAP_MAX}) ? CAP_MAX : full[39:0];
        endfunction

        function void set_cost(logic [32:0] q);
            cost = (q == '0) ? 34'd1 : {1'b0, q};
        endfunction

        function t_out_item take_request(t_in_item req);
            t_out_item   res;
            logic [63:0] gain;
            logic [63:0] debit;
            logic [63:0] quo;
            logic [32:0] q;
            res.grant_count = '0;
            case (req.mode)
                MODE_START: begin
                    credits  = '0;
                    rate_pos = '0;
                    last_ts  = req.timestamp;
                    step_ts  = req.timestamp;
                    q = cycles_per_packet(trace_on ? rate_table[0] : fixed_rate);
                    set_cap(q);
                    set_cost(q);
                end
                MODE_POLL: begin
                    gain    = req.timestamp - last_ts;
                    last_ts = req.timestamp;
                    credits = (credits > ~gain) ? '1 : credits + gain;
                    if (cost != '0 && credits >= {30'b0, cost}) begin
                        quo = credits / {30'b0, cost};
                        res.grant_count = (quo > BURST) ? 6'(BURST) : quo[5:0];
                    end
                end
                MODE_REPORT: begin
                    debit   = {58'b0, req.sent_count} * {30'b0, cost};
                    credits = (credits > debit) ? credits - debit : '0;
                    if (credits > {24'b0, cap}) credits = {24'b0, cap};
                    if (trace_on) begin
                        // advance one table entry once a second has gone by
                        if (req.timestamp - step_ts > {31'b0, clock_hz}) begin
                            step_ts  = req.timestamp;
                            rate_pos = (rate_pos + 1 < TABLE_LEN) ? rate_pos + 6'd1 : '0;
                            set_cap(cycles_per_packet(rate_table[rate_pos]));
                        end
                        set_cost(cycles_per_packet(rate_table[rate_pos]));
                    end
                end
                MODE_TWRITE: begin
                    if (req.table_index < TABLE_LEN) rate_table[req.table_index] = req.table_rate;
                end
                default: ;
            endcase
            res.rate_step      = rate_pos;
            res.credit_balance = credits;
            owed_results.push_back(res);
            return res;
        endfunction

        function void flag(string what, logic [63:0] want, logic [63:0] got);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch in %s: expected %0h, got %0h", what, want, got);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (owed_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result with none owed: grant %0d, step %0d, balance %0h",
                             got.grant_count, got.rate_step, got.credit_balance);
                return;
            end
            want = owed_results.pop_front();
            if (got.grant_count !== want.grant_count)
                flag("grant_count", want.grant_count, got.grant_count);
            if (got.rate_step !== want.rate_step)
                flag("rate_step", want.rate_step, got.rate_step);
            if (got.credit_balance !== want.credit_balance)
                flag("credit_balance", want.credit_balance, got.credit_balance);
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_in_item              in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    grant_ledger  ledger;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           results_seen = 0;
    int           hold_left = 0;
    logic [63:0]  ts_cursor = '0;
    logic [5:0]   last_grant = '0;
    int unsigned  rate_span = 5000;

    credit_packet_rate_limiter i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Check each result taken, then pick the next ready; hold ready low for a
    // long stretch once so the block backs up and stalls its input.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            ledger.check_result(out_data);
            results_seen++;
            if (results_seen == HOLD_AT) hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog: end the run if it hangs.
    initial begin
        for (int cycle = 0; cycle < CYCLE_LIMIT; cycle++) @(posedge clk);
        $display("testbench NOT OK");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_below(logic [63:0] lim);
        return (lim == '0) ? '0 : rand64() % lim;
    endfunction

    function automatic t_in_item make_request(t_mode mode, logic [63:0] ts, logic [5:0] sent,
                                              logic [5:0] index, logic [31:0] rate);
        t_in_item req;
        req.mode        = mode;
        req.timestamp   = ts;
        req.sent_count  = sent;
        req.table_index = index;
        req.table_rate  = rate;
        return req;
    endfunction

    // Mostly well-formed traffic: polls and reports on a rising clock count
    // with steps sized to the current cost, reports owning up to the last
    // grant; the rest is table writes, restarts, over-reports and noise.
    function automatic t_in_item next_request();
        t_in_item    req;
        int unsigned pick;
        logic [63:0] span;
        req.mode        = MODE_POLL;
        req.timestamp   = rand64();
        req.sent_count  = 6'($urandom_range(0, BURST));
        req.table_index = 6'($urandom_range(0, TABLE_LEN - 1));
        req.table_rate  = $urandom;
        span = {30'b0, ledger.cost} * 64'd40 + 64'd16;
        pick = $urandom_range(0, 99);
        if (pick < 92) ts_cursor += rand_below(span);
        if (pick < 4) begin
            req.mode      = MODE_START;
            req.timestamp = ts_cursor;
        end else if (pick < 46) begin
            req.mode      = MODE_POLL;
            req.timestamp = ts_cursor;
        end else if (pick < 84) begin
            // jump past a second now and then to force a table step
            if ($urandom_range(0, 7) == 0) ts_cursor += {31'b0, ledger.clock_hz} + 64'd1;
            req.mode      = MODE_REPORT;
            req.timestamp = ts_cursor;
            if ($urandom_range(0, 3) != 0) req.sent_count = 6'($urandom_range(0, last_grant));
        end else if (pick < 92) begin
            req.mode = MODE_TWRITE;
            if ($urandom_range(0, 7) != 0) req.table_rate = $urandom_range(0, rate_span);
        end else begin
            req.mode = t_mode'(2'($urandom_range(0, 3)));
        end
        return req;
    endfunction

    // Hold the request until accepted, then book its prediction.
    task automatic send_request(input t_in_item req);
        t_out_item res;
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (!in_ready);
        res = ledger.take_request(req);
        last_grant = res.grant_count;
    endtask

    // Leaves cfg_valid high; the caller drops it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        ledger.write_reg(index, data);
    endtask

    // Drop valid and wait until every owed result is back.
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (ledger.owed_results.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_idling(input t_idle_plan plan);
        send_idle_pct = (plan == IDLE_SENDER) ? 56 : (plan == IDLE_BOTH) ? 12 : 0;
        @(negedge clk);
        recv_stall_pct = (plan == IDLE_RECEIVER) ? 56 : (plan == IDLE_BOTH) ? 12 : 0;
        @(posedge clk);
    endtask

    // Load every table entry so trace mode never reads an unwritten one.
    task automatic fill_rate_table(input int unsigned span);
        logic [31:0] rate;
        for (int i = 0; i < TABLE_LEN; i++) begin
            rate = (i == 5) ? 32'd0 : (i == 9) ? '1 : $urandom_range(0, span);
            send_request(make_request(MODE_TWRITE, rand64(), '0, 6'(i), rate));
        end
        settle();
    endtask

    task automatic run_phase(input t_idle_plan plan, input logic [32:0] hz,
                             input logic [6:0] senders, input logic [31:0] rate,
                             input logic trace, input int unsigned span, input int items,
                             input bit poke_unused);
        set_idling(plan);
        if (poke_unused) write_reg(CFG_UNUSED, 33'h1_2345_6789);
        write_reg(CFG_CLOCK_HZ, hz);
        write_reg(CFG_SENDER_COUNT, {26'b0, senders});
        write_reg(CFG_FIXED_RATE, {1'b0, rate});
        write_reg(CFG_TRACE_ENABLE, {32'b0, trace});
        cfg_valid <= 1'b0;
        rate_span = span;
        ts_cursor = rand64();
        // open each phase with a start so sequences begin well-formed
        send_request(make_request(MODE_START, ts_cursor, '0, '0, '0));
        for (int n = 1; n < items; n++) send_request(next_request());
        settle();
    endtask

    initial begin
        ledger = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests on the reset settings (cap 32000).
        set_idling(IDLE_NONE);
        send_request(make_request(MODE_POLL, 64'd100, '0, '0, '0));       // poll before start
        send_request(make_request(MODE_REPORT, 64'd150, 6'd32, '0, '0));  // report, cap still zero
        send_request(make_request(MODE_START, 64'd1000, '0, '0, '0));
        send_request(make_request(MODE_POLL, 64'd1999, '0, '0, '0));      // one short of a packet
        send_request(make_request(MODE_POLL, 64'd2000, '0, '0, '0));      // exactly one packet
        send_request(make_request(MODE_REPORT, 64'd2000, 6'd1, '0, '0));
        send_request(make_request(MODE_POLL, 64'd102000, '0, '0, '0));    // grant capped at burst
        send_request(make_request(MODE_REPORT, 64'd102000, 6'd0, '0, '0)); // clamp to cap
        send_request(make_request(MODE_REPORT, 64'd102001, 6'd32, '0, '0)); // report equals the balance
        send_request(make_request(MODE_POLL, '1, '0, '0, '0));
        send_request(make_request(MODE_POLL, 64'd200000, '0, '0, '0));    // sum saturates
        send_request(make_request(MODE_REPORT, 64'd200000, 6'd3, '0, '0));
        send_request(make_request(MODE_TWRITE, '0, '0, 6'd0, 32'd0));
        send_request(make_request(MODE_TWRITE, '0, '0, 6'd63, '1));
        send_request(make_request(MODE_TWRITE, '1, 6'd63, 6'd42, 32'h5555_AAAA));
        send_request(make_request(MODE_START, 64'hFFFF_FFFF_FFFF_FFF0, '0, '0, '0));
        send_request(make_request(MODE_POLL, 64'h10, '0, '0, '0));        // timestamp wraps
        settle();

        run_phase(IDLE_SENDER, 33'd1000000000, 7'd1, 32'd1000000, 1'b0, 5000, 100, 1'b0);
        // slowest clock share: one packet per second per sender
        run_phase(IDLE_RECEIVER, '1, 7'd64, 32'd1, 1'b0, 5000, 90, 1'b0);
        // rate above the clock, zero sender count
        run_phase(IDLE_BOTH, 33'd1, 7'd0, '1, 1'b0, 5000, 60, 1'b0);

        fill_rate_table(5000);
        // tiny second: reports step the table often and wrap it
        run_phase(IDLE_NONE, 33'd64, 7'd3, 32'd7, 1'b1, 5000, 180, 1'b0);
        run_phase(IDLE_SENDER, 33'd1000000, 7'd64, 32'd12345, 1'b1, 5000, 120, 1'b0);

        fill_rate_table('1);
        run_phase(IDLE_RECEIVER, 33'd250000000, 7'd2, 32'd3000000, 1'b1, '1, 110, 1'b0);
        run_phase(IDLE_BOTH, 33'd1000000000, 7'd1, 32'd1000000, 1'b0, 5000, 95, 1'b1);

        in_valid <= 1'b0;
        do @(posedge clk); while (ledger.owed_results.size() != 0);
        repeat (100) @(posedge clk);
        if (ledger.mismatches == 0 && ledger.owed_results.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
